### hw/rtl/bac_pkg.sv
// Shared types and constants of the byte accumulator step block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bac_pkg;

   // Request operation codes (req_tuser)
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_EXEC    = 2'd1;
   localparam logic [1:0] OP_SETEXEC = 2'd2;
   localparam logic [1:0] OP_RESET   = 2'd3;

   // Instruction opcodes
   localparam logic [7:0] OPC_LDI  = 8'h50;
   localparam logic [7:0] OPC_STW  = 8'h51;
   localparam logic [7:0] OPC_ADD  = 8'h5A;
   localparam logic [7:0] OPC_SUB  = 8'h5B;
   localparam logic [7:0] OPC_JMP  = 8'h6E;
   localparam logic [7:0] OPC_BNE  = 8'h70;
   localparam logic [7:0] OPC_HALT = 8'hFF;

   // Result status codes (rsp_tuser)
   localparam logic [2:0] ST_EXEC     = 3'd0;
   localparam logic [2:0] ST_HALT     = 3'd1;
   localparam logic [2:0] ST_INVALID  = 3'd2;
   localparam logic [2:0] ST_PAST     = 3'd3;
   localparam logic [2:0] ST_BADSTART = 3'd4;
   localparam logic [2:0] ST_DONE     = 3'd5;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 56;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Work kinds after classification in the front end
   typedef enum logic [2:0] {
      K_LOAD,
      K_EXEC,
      K_SETEXEC,
      K_RESET,
      K_BADSTART
   } bac_kind_type;

   typedef struct packed {
      bac_kind_type kind;
      logic [15:0]  addr;
      logic [7:0]   data;
   } bac_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } bac_qstat_type;

   typedef struct packed {
      logic clearing;
   } bac_bstat_type;

   typedef enum logic [2:0] {
      B_CLR,
      B_IDLE,
      B_F1,
      B_F2,
      B_F3,
      B_EX
   } bac_bstate_type;

endpackage

### hw/rtl/byte_accumulator_cpu_step.sv
// Top level of the byte accumulator step block: front end, work queue, back end.
// Depends on bac_pkg, bac_front, bac_queue and bac_back.
`timescale 1ns / 1ps

// Usage
//  req channel: one word per command. req_tuser = op (load byte, execute,
//    set PC and execute, reset PC/W); req_tdata = address, load byte.
//  rsp channel: exactly one word per request word, in order.
//    rsp_tuser = status; rsp_tdata = PC, W and the fetched opcode.
// Sequencing / throughput
//  A request word lands in a 2-deep queue; the back end pops it from B_IDLE.
//  Load, reset and bad-start words finish in B_IDLE, so they run at one
//  word per cycle while the result register is taken. An execute steps
//  through B_IDLE (pop and opcode read), B_F1 to B_F3 (three operand reads
//  through the single memory port) and B_EX (execute and write back).
//  rsp_tvalid is registered from B_IDLE (simple) or B_EX (execute).
// Reset
//  Synchronous reset clears PC and W, then a clearing pass zeroes the
//  program memory one byte per cycle; req_tready is low during the pass.
// Stall
//  The result register holds until taken; the back end waits at its final
//  step, the queue fills and req_tready drops once it holds two words.
module byte_accumulator_cpu_step #(
   parameter int MEM_BYTES = 1536
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [bac_pkg::REQ_DATA_W-1:0] req_tdata,  // address[15:0], load_byte[23:16]
   input  logic [1:0]                     req_tuser,  // op[1:0]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bac_pkg::RSP_DATA_W-1:0] rsp_tdata,  // pc_out[15:0], w_out[47:16],
                                                      // opcode_seen[55:48]
   output logic [2:0]                     rsp_tuser   // status[2:0]
);
   import bac_pkg::*;

   bac_qstat_type q_stat;
   bac_bstat_type bk_stat;
   bac_item_type  push_item, head;
   logic          push, pop;

   // classify incoming words
   bac_front #(.MEM_BYTES(MEM_BYTES)) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_stat     (q_stat),
      .bk_stat    (bk_stat),
      .push       (push),
      .item       (push_item)
   );

   // decouples acceptance from execution
   bac_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   // memory, PC/W and the fetch/execute sequencer
   bac_back #(.MEM_BYTES(MEM_BYTES)) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_stat     (q_stat),
      .pop        (pop),
      .bk_stat    (bk_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef SYNTHESIS
   // no word may enter while memory is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      bk_stat.clearing |-> !req_tready)
      else $error("request accepted during memory clear");

   // a reported PC never lies above the top of memory
   a_pc_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ({1'b0, rsp_tdata[15:0]} < 17'(MEM_BYTES)))
      else $error("result PC above top of memory");

   // loads, resets and bad starts fetch nothing
   a_no_opcode_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_DONE || rsp_tuser == ST_BADSTART)
      |-> (rsp_tdata[55:48] == 8'd0))
      else $error("opcode reported without a fetch");

   // the queue is never pushed while full
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("queue overflow");
`endif

endmodule

### hw/rtl/bac_front.sv
// Front end: accepts request words and classifies them into work items.
// Depends on bac_pkg.
`timescale 1ns / 1ps

module bac_front #(
   parameter int MEM_BYTES = 1536
) (
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bac_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [1:0]                        req_tuser,
   input  bac_pkg::bac_qstat_type            q_stat,
   input  bac_pkg::bac_bstat_type            bk_stat,
   output logic                              push,
   output bac_pkg::bac_item_type             item
);
   import bac_pkg::*;

   localparam logic [16:0] TOP = 17'(MEM_BYTES - 1);

   assign req_tready = !q_stat.full && !bk_stat.clearing;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      item.addr = req_tdata[15:0];
      item.data = req_tdata[23:16];
      unique case (req_tuser)
         OP_LOAD:    item.kind = K_LOAD;
         OP_EXEC:    item.kind = K_EXEC;
         OP_SETEXEC: item.kind = ({1'b0, req_tdata[15:0]} > TOP) ? K_BADSTART : K_SETEXEC;
         OP_RESET:   item.kind = K_RESET;
         default:    item.kind = K_RESET;
      endcase
   end

endmodule

### hw/rtl/bac_queue.sv
// Short FIFO of classified work items between front and back end.
// Depends on bac_pkg.
`timescale 1ns / 1ps

module bac_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bac_pkg::bac_item_type  push_item,
   input  logic                   pop,
   output bac_pkg::bac_item_type  head,
   output bac_pkg::bac_qstat_type q_stat
);
   import bac_pkg::*;

   bac_item_type        entries_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QDEPTH - 1);
   localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QDEPTH);

   assign head         = entries_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_FULL);
   assign q_stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_item;
   end

endmodule

### hw/rtl/bac_back.sv
// Back end: program memory, PC/W state, instruction sequencer, result register.
// Depends on bac_pkg.
`timescale 1ns / 1ps

module bac_back #(
   parameter int MEM_BYTES = 1536
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bac_pkg::bac_item_type          head,
   input  bac_pkg::bac_qstat_type         q_stat,
   output logic                           pop,
   output bac_pkg::bac_bstat_type         bk_stat,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [bac_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [2:0]                     rsp_tuser
);
   import bac_pkg::*;

   localparam int          AW       = $clog2(MEM_BYTES);
   localparam logic [16:0] TOP      = 17'(MEM_BYTES - 1);
   localparam logic [16:0] MEM_LIM  = 17'(MEM_BYTES);
   localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

   bac_bstate_type state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [15:0]    pc_ff, pc_in;
   logic [31:0]    w_ff, w_in;
   logic [7:0]     opc_ff, opc_in;
   logic [7:0]     b1_ff, b1_in;
   logic [7:0]     b2_ff, b2_in;
   logic           rd_ok_ff, rd_ok_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [15:0]    rsp_pc_ff, rsp_pc_in;
   logic [31:0]    rsp_w_ff, rsp_w_in;
   logic [7:0]     rsp_opc_ff, rsp_opc_in;

   logic [7:0]     mem [MEM_BYTES];
   logic [7:0]     mem_q_ff;
   logic           mem_we, mem_re;
   logic [AW-1:0]  mem_addr;
   logic [7:0]     mem_wd;

   logic           out_free, fire;
   logic           head_simple, exec_bad;
   logic [16:0]    pc17, rd_addr;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign pc17        = {1'b0, pc_ff};
   assign head_simple = (head.kind == K_LOAD) || (head.kind == K_RESET) ||
                        (head.kind == K_BADSTART);
   // PC above the top at an execute; kept for safety
   assign exec_bad    = (head.kind == K_EXEC) && (pc17 > TOP);

   assign bk_stat.clearing = (state_ff == B_CLR);

   always_comb begin : next_state
      state_in = state_ff;
      unique case (state_ff)
         B_CLR:  if (clr_ff == CLR_LAST) state_in = B_IDLE;
         B_IDLE: if (!q_stat.empty && !head_simple && !exec_bad) state_in = B_F1;
         B_F1:   state_in = B_F2;
         B_F2:   state_in = B_F3;
         B_F3:   state_in = B_EX;
         B_EX:   if (out_free) state_in = B_IDLE;
         default: state_in = B_CLR;
      endcase
   end

   always_comb begin : datapath
      logic [7:0]  b3;
      logic [16:0] nxt;
      logic [31:0] w_new;
      logic [15:0] loc;
      logic        known, store;

      clr_in        = clr_ff;
      pc_in         = pc_ff;
      w_in          = w_ff;
      opc_in        = opc_ff;
      b1_in         = b1_ff;
      b2_in         = b2_ff;
      rd_ok_in      = rd_ok_ff;
      pop           = 1'b0;
      fire          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_opc_in    = rsp_opc_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = '0;
      mem_wd        = '0;
      rd_addr       = '0;
      b3            = rd_ok_ff ? mem_q_ff : 8'd0;
      nxt           = '0;
      w_new         = w_ff;
      loc           = {b1_ff, b2_ff};
      known         = 1'b1;
      store         = 1'b0;

      unique case (state_ff)
         B_CLR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + 1'b1;
         end
         B_IDLE: begin
            if (!q_stat.empty) begin
               if (head_simple || exec_bad) begin
                  if (out_free) begin
                     pop           = 1'b1;
                     fire          = 1'b1;
                     rsp_opc_in    = 8'd0;
                     rsp_status_in = ST_DONE;
                     case (head.kind)
                        K_LOAD: begin
                           mem_we   = ({1'b0, head.addr} < MEM_LIM);
                           mem_addr = head.addr[AW-1:0];
                           mem_wd   = head.data;
                        end
                        K_RESET: begin
                           pc_in = '0;
                           w_in  = '0;
                        end
                        K_BADSTART: rsp_status_in = ST_BADSTART;
                        default:    rsp_status_in = ST_PAST;
                     endcase
                     rsp_pc_in = (head.kind == K_RESET) ? 16'd0 : pc_ff;
                     rsp_w_in  = (head.kind == K_RESET) ? 32'd0 : w_ff;
                  end
               end else begin
                  // start fetch of the opcode byte
                  pop      = 1'b1;
                  mem_re   = 1'b1;
                  if (head.kind == K_SETEXEC) begin
                     pc_in    = head.addr;
                     mem_addr = head.addr[AW-1:0];
                  end else begin
                     mem_addr = pc_ff[AW-1:0];
                  end
               end
            end
         end
         B_F1, B_F2, B_F3: begin
            if (state_ff == B_F1) begin
               opc_in  = mem_q_ff;
               rd_addr = pc17 + 17'd1;
            end else if (state_ff == B_F2) begin
               b1_in   = rd_ok_ff ? mem_q_ff : 8'd0;
               rd_addr = pc17 + 17'd2;
            end else begin
               b2_in   = rd_ok_ff ? mem_q_ff : 8'd0;
               rd_addr = pc17 + 17'd3;
            end
            mem_re   = 1'b1;
            mem_addr = rd_addr[AW-1:0];
            rd_ok_in = (rd_addr < MEM_LIM);
         end
         B_EX: begin
            unique case (opc_ff) inside
               OPC_LDI, OPC_ADD, OPC_SUB: begin
                  nxt = pc17 + 17'd2;
                  if (opc_ff == OPC_LDI)      w_new = {24'd0, b1_ff};
                  else if (opc_ff == OPC_ADD) w_new = w_ff + {24'd0, b1_ff};
                  else                        w_new = w_ff - {24'd0, b1_ff};
               end
               OPC_STW: begin
                  nxt   = pc17 + 17'd3;
                  store = ({1'b0, loc} < MEM_LIM);
               end
               OPC_JMP: nxt = {1'b0, b1_ff, b2_ff};
               OPC_BNE: nxt = (w_ff == {24'd0, b1_ff}) ? pc17 + 17'd4 : {1'b0, b2_ff, b3};
               default: known = 1'b0;
            endcase

            if (out_free) begin
               fire       = 1'b1;
               rsp_opc_in = opc_ff;
               rsp_pc_in  = pc_ff;
               rsp_w_in   = w_ff;
               if (opc_ff == OPC_HALT) begin
                  rsp_status_in = ST_HALT;
               end else if (!known) begin
                  rsp_status_in = ST_INVALID;
               end else if (nxt > TOP) begin
                  rsp_status_in = ST_PAST;
               end else begin
                  rsp_status_in = ST_EXEC;
                  pc_in         = nxt[15:0];
                  w_in          = w_new;
                  rsp_pc_in     = nxt[15:0];
                  rsp_w_in      = w_new;
                  mem_we        = store;
                  mem_addr      = loc[AW-1:0];
                  mem_wd        = w_ff[7:0];
               end
            end
         end
         default: ;
      endcase

      rsp_valid_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         w_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         w_ff         <= w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opc_ff        <= opc_in;
      b1_ff         <= b1_in;
      b2_ff         <= b2_in;
      rd_ok_ff      <= rd_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_w_ff      <= rsp_w_in;
      rsp_opc_ff    <= rsp_opc_in;
   end

   // single-port program memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      if (mem_re) mem_q_ff <= mem[mem_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_opc_ff, rsp_w_ff, rsp_pc_ff};

endmodule

### dv/tb.sv
// Self-checking testbench for byte_accumulator_cpu_step: queue-fed stream driver,
// stream monitor, and an in-bench predictor of memory, PC and W.
// Depends on bac_pkg and the RTL of byte_accumulator_cpu_step.
`timescale 1ns / 1ps

module tb;
   import bac_pkg::*;

   localparam int MEM_BYTES = 1536;
   localparam int CMD_GOAL  = 1950;   // random command words after the directed part
   localparam int DRAIN_CYC = 30;     // settle time after the last response
   localparam int HOLD_CYC  = 250;    // long receiver hold-off

   // One command word and one step result, at the block's field widths
   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] addr;
      logic [7:0]  data;
   } cmd_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] pc;
      logic [31:0] w;
      logic [7:0]  opcode;
   } step_result_type;

   // Clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   // DUT ports
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // address[15:0], load_byte[23:16]
   logic [1:0]            req_tuser  = '0;   // op[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // pc_out[15:0], w_out[47:16], opcode_seen[55:48]
   logic [2:0]            rsp_tuser;         // status[2:0]

   byte_accumulator_cpu_step #(
      .MEM_BYTES (MEM_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Predictor state: program memory image, PC, W
   logic [7:0]  mem_img [MEM_BYTES];
   logic [15:0] pc_q;
   logic [31:0] w_q;

   cmd_word_type    cmd_backlog[$];     // words not yet offered
   step_result_type expected_steps[$];  // predicted results, oldest first
   cmd_word_type    cur_word;           // word currently on the req bus

   int  cmd_total     = 0;
   int  accepted_words = 0;
   int  checked_words  = 0;
   int  error_cnt      = 0;
   int  status_count[8];
   logic rsp_hold = 1'b0;            // long hold-off on the result side

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   // operand fetch: above the top of memory reads as zero
   function automatic logic [7:0] mem_byte(int a);
      return (a < MEM_BYTES) ? mem_img[a] : 8'h00;
   endfunction

   // Applies one command word to the predicted state, returns the result word.
   function automatic step_result_type cpu_step(cmd_word_type c);
      step_result_type r;
      int           pc, nxt, loc;
      logic [7:0]   opc, b1, b2, b3;
      r.status = ST_DONE;
      r.opcode = 8'h00;
      case (c.op)
         OP_LOAD: begin
            if (c.addr < MEM_BYTES) mem_img[c.addr] = c.data;  // beyond top: dropped
         end
         OP_RESET: begin
            pc_q = '0;   // memory is kept
            w_q  = '0;
         end
         default: begin
            if (c.op == OP_SETEXEC && c.addr > MEM_BYTES - 1) begin
               r.status = ST_BADSTART;
            end else begin
               if (c.op == OP_SETEXEC) pc_q = c.addr;
               pc = pc_q;
               nxt = 0;
               if (pc > MEM_BYTES - 1) begin
                  r.status = ST_PAST;
               end else begin
                  opc = mem_img[pc];
                  r.opcode = opc;
                  b1 = mem_byte(pc + 1);
                  b2 = mem_byte(pc + 2);
                  b3 = mem_byte(pc + 3);
                  r.status = ST_EXEC;
                  case (opc)
                     OPC_LDI, OPC_ADD, OPC_SUB: nxt = pc + 2;
                     OPC_STW:  nxt = pc + 3;
                     OPC_JMP:  nxt = int'({b1, b2});
                     OPC_BNE:  nxt = (w_q == {24'h0, b1}) ? pc + 4 : int'({b2, b3});
                     OPC_HALT: r.status = ST_HALT;
                     default:  r.status = ST_INVALID;
                  endcase
                  // any move past the top leaves the state untouched
                  if (r.status == ST_EXEC && nxt > MEM_BYTES - 1) r.status = ST_PAST;
                  if (r.status == ST_EXEC) begin
                     case (opc)
                        OPC_LDI: w_q = {24'h0, b1};
                        OPC_ADD: w_q = w_q + {24'h0, b1};
                        OPC_SUB: w_q = w_q - {24'h0, b1};
                        OPC_STW: begin
                           loc = int'({b1, b2});
                           if (loc < MEM_BYTES) mem_img[loc] = w_q[7:0];
                        end
                        default: ;
                     endcase
                     pc_q = nxt[15:0];
                  end
               end
            end
         end
      endcase
      r.pc = pc_q;
      r.w  = w_q;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   task automatic add_cmd(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
      cmd_word_type c;
      c.op   = op;
      c.addr = addr;
      c.data = data;
      cmd_backlog.push_back(c);
   endtask

   // small values make BNE compare equal often
   function automatic logic [7:0] pick_operand();
      return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
   endfunction

   // jump, branch and store targets: mostly inside the program, some anywhere
   function automatic logic [15:0] pick_target(int base);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'(base + $urandom_range(0, 24));
      if (r < 85) return 16'($urandom_range(0, MEM_BYTES - 1));
      return 16'($urandom);
   endfunction

   // Loads a short random program, points PC at it and steps through it.
   task automatic add_program();
      logic [7:0]  code[$];
      logic [15:0] tgt;
      int          base, n_ins, n_runs, r;
      base = ($urandom_range(0, 4) == 0) ? $urandom_range(MEM_BYTES - 8, MEM_BYTES - 1)
                                         : $urandom_range(0, MEM_BYTES - 64);
      n_ins = $urandom_range(2, 7);
      repeat (n_ins) begin
         r = $urandom_range(0, 99);
         if (r < 16) begin
            code.push_back(OPC_LDI);
            code.push_back(pick_operand());
         end else if (r < 28) begin
            code.push_back(OPC_ADD);
            code.push_back(pick_operand());
         end else if (r < 40) begin
            code.push_back(OPC_SUB);
            code.push_back(pick_operand());
         end else if (r < 52) begin
            tgt = pick_target(base);
            code.push_back(OPC_STW);
            code.push_back(tgt[15:8]);
            code.push_back(tgt[7:0]);
         end else if (r < 62) begin
            tgt = pick_target(base);
            code.push_back(OPC_JMP);
            code.push_back(tgt[15:8]);
            code.push_back(tgt[7:0]);
         end else if (r < 82) begin
            tgt = pick_target(base);
            code.push_back(OPC_BNE);
            code.push_back(pick_operand());
            code.push_back(tgt[15:8]);
            code.push_back(tgt[7:0]);
         end else if (r < 90) begin
            code.push_back(OPC_HALT);
         end else begin
            code.push_back(8'($urandom));   // mostly not a valid opcode
         end
      end
      foreach (code[i]) add_cmd(OP_LOAD, 16'(base + i), code[i]);
      add_cmd(OP_SETEXEC, 16'(base), 8'($urandom));
      n_runs = $urandom_range(2, n_ins + 4);
      repeat (n_runs) begin
         if ($urandom_range(0, 29) == 0) add_cmd(OP_RESET, 16'($urandom), 8'($urandom));
         else add_cmd(OP_EXEC, 16'($urandom), 8'($urandom));
      end
   endtask

   function automatic bit roll_idle(int done_cnt);
      // quiet window: no idling at all
      if (done_cnt >= 600 && done_cnt < 900) return 1'b0;
      return $urandom_range(0, 99) < 7;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      $display("%0d ns: word %0d, %s expected 0x%0h, got 0x%0h",
               $time, checked_words, field, want, got);
      error_cnt++;
   endtask

   // ------------------------------------------------------------------
   // Driver: offers queued words, predicts on each accepted one
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_steps.push_back(cpu_step(cur_word));
            accepted_words++;
         end
         // valid only drops when nothing is pending on the bus
         if (!req_tvalid || req_tready) begin
            if (cmd_backlog.size() != 0 && !roll_idle(accepted_words)) begin
               cur_word = cmd_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {cur_word.data, cur_word.addr};
               req_tuser  <= cur_word.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: checks each taken result word against the oldest prediction
   // ------------------------------------------------------------------
   step_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_steps.size() == 0) begin
               report_mismatch("unexpected word, status", 32'h0, 32'(rsp_tuser));
            end else begin
               want = expected_steps.pop_front();
               if (rsp_tuser !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_tuser));
               if (rsp_tdata[15:0] !== want.pc)
                  report_mismatch("pc_out", 32'(want.pc), 32'(rsp_tdata[15:0]));
               if (rsp_tdata[47:16] !== want.w)
                  report_mismatch("w_out", want.w, rsp_tdata[47:16]);
               if (rsp_tdata[55:48] !== want.opcode)
                  report_mismatch("opcode_seen", 32'(want.opcode), 32'(rsp_tdata[55:48]));
            end
            status_count[rsp_tuser]++;
            checked_words++;
         end
         rsp_tready <= !rsp_hold && !roll_idle(checked_words);
      end
   end

   // Long receiver hold-off so the queue fills and req_tready drops
   initial begin
      wait (accepted_words >= 300);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYC) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Reset: held from the start, released once, never again
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog: bounds the clearing pass plus ~2k words
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      foreach (mem_img[i]) mem_img[i] = 8'h00;   // block reset clears memory
      pc_q = '0;
      w_q  = '0;
      foreach (status_count[i]) status_count[i] = 0;

      // Directed part
      add_cmd(OP_RESET,   16'h0000, 8'h00);
      add_cmd(OP_EXEC,    16'h0000, 8'h00);            // zero byte: invalid opcode
      add_cmd(OP_LOAD,    16'hFFFF, 8'hFF);            // load beyond top, ignored
      add_cmd(OP_SETEXEC, 16'hFFFF, 8'hFF);            // bad start address
      add_cmd(OP_SETEXEC, 16'(MEM_BYTES), 8'h00);      // first address past top
      // jump at the top byte: both operands read as zero, lands on 0
      add_cmd(OP_LOAD,    16'(MEM_BYTES - 1), OPC_JMP);
      add_cmd(OP_SETEXEC, 16'(MEM_BYTES - 1), 8'h00);
      // load immediate one below the top: next PC is past top
      add_cmd(OP_LOAD,    16'(MEM_BYTES - 2), OPC_LDI);
      add_cmd(OP_SETEXEC, 16'(MEM_BYTES - 2), 8'h00);
      // subtract from zero wraps W to all ones
      add_cmd(OP_LOAD,    16'd0, OPC_SUB);
      add_cmd(OP_LOAD,    16'd1, 8'h01);
      add_cmd(OP_SETEXEC, 16'd0, 8'h00);
      // add wraps back to 1
      add_cmd(OP_LOAD,    16'd2, OPC_ADD);
      add_cmd(OP_LOAD,    16'd3, 8'h02);
      add_cmd(OP_EXEC,    16'd0, 8'h00);
      // store to 0xFFFF: nothing written, PC still moves
      add_cmd(OP_LOAD,    16'd4, OPC_STW);
      add_cmd(OP_LOAD,    16'd5, 8'hFF);
      add_cmd(OP_LOAD,    16'd6, 8'hFF);
      add_cmd(OP_EXEC,    16'd0, 8'h00);
      // branch with W equal to operand: falls through
      add_cmd(OP_LOAD,    16'd7, OPC_BNE);
      add_cmd(OP_LOAD,    16'd8, 8'h01);
      add_cmd(OP_LOAD,    16'd9, 8'h00);
      add_cmd(OP_LOAD,    16'd10, 8'h00);
      add_cmd(OP_EXEC,    16'd0, 8'h00);
      // halt, and halt again on the next step
      add_cmd(OP_LOAD,    16'd11, OPC_HALT);
      add_cmd(OP_EXEC,    16'd0, 8'h00);
      add_cmd(OP_EXEC,    16'd0, 8'h00);

      // Random part: mostly well-formed programs, some stray words
      cmd_total = cmd_backlog.size() + CMD_GOAL;
      while (cmd_backlog.size() < cmd_total) begin
         if ($urandom_range(0, 99) < 80) add_program();
         else add_cmd(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
      end
      cmd_total = cmd_backlog.size();

      wait (accepted_words == cmd_total);
      while (expected_steps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);

      $display("Ran %0d command words; results: %0d executed, %0d halted, %0d invalid,",
               cmd_total, status_count[ST_EXEC], status_count[ST_HALT],
               status_count[ST_INVALID]);
      $display("  %0d past top, %0d bad start, %0d load/reset; %0d field mismatches",
               status_count[ST_PAST], status_count[ST_BADSTART], status_count[ST_DONE],
               error_cnt);
      if (error_cnt == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
